FILE: rtl/tcpal_pkg.sv
// Shared types, constants and scaling tables for the truecolour palette unit.
`default_nettype none

package tcpal_pkg;

   localparam int FULL_SCALE = 1000;
   localparam int GUN32      = 255;
   localparam int GUN16      = 31;
   localparam int GUN16X2    = 62;

   // Reciprocal of 125 for the forward scaling: floor(m/125) = (m*RECIP) >> RECIP_SHIFT
   // holds for every m below 59074, well above the largest m of 31937.
   localparam logic [15:0] RECIP       = 16'd33555;
   localparam int          RECIP_SHIFT = 22;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_DEPTH_MODE = 2'd0;
   localparam logic [1:0] REG_GREEN_SIX  = 2'd1;
   localparam logic [1:0] REG_OR_MASK    = 2'd2;
   localparam logic [1:0] REG_AND_MASK   = 2'd3;

   localparam logic [0:0] OP_SET   = 1'b0;
   localparam logic [0:0] OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_WRITE,
      ST_READ,
      ST_FORMAT
   } state_type;

   typedef struct packed {
      logic        depth_mode;
      logic        green_six_bit;
      logic [15:0] or_mask;
      logic [15:0] and_mask;
   } cfg_type;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] pen;
      logic signed [15:0] red_in;
      logic signed [15:0] green_in;
      logic signed [15:0] blue_in;
      logic               report_realized;
   } req_item_type;

   typedef struct packed {
      logic signed [8:0]  pen_echo;
      logic signed [15:0] red_out;
      logic signed [15:0] green_out;
      logic signed [15:0] blue_out;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic load_scale;
      logic load_quot;
      logic ram_we;
      logic ram_re;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic new_query;
      logic pen_ok;
      logic out_free;
   } sts_type;

   // Gun value back to thousandths: round(g*1000/max), halves up
   typedef logic [9:0] back8_table_type [256];
   typedef logic [9:0] back5_table_type [32];
   typedef logic [9:0] back6_table_type [64];

   function automatic back8_table_type build_back8();
      back8_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 10'((2 * i * FULL_SCALE + GUN32) / (2 * GUN32));
      end
      return t;
   endfunction

   function automatic back5_table_type build_back5();
      back5_table_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 10'((2 * i * FULL_SCALE + GUN16) / (2 * GUN16));
      end
      return t;
   endfunction

   function automatic back6_table_type build_back6();
      back6_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 10'((2 * i * FULL_SCALE + GUN16X2) / (2 * GUN16X2));
      end
      return t;
   endfunction

   localparam back8_table_type BACK8 = build_back8();
   localparam back5_table_type BACK5 = build_back5();
   localparam back6_table_type BACK6 = build_back6();

endpackage

`default_nettype wire

FILE: rtl/tcpal_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tcpal_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/tcpal_ctrl.sv
// Sequencer for set and query words.
`default_nettype none

module tcpal_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire tcpal_pkg::sts_type sts,
   output tcpal_pkg::cmd_type     cmd
);
   import tcpal_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sts.new_query ? ST_READ : ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.load_scale = 1'b1;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.load_quot = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.ram_we = sts.pen_ok;
            state_in   = ST_IDLE;
         end
         ST_READ: begin
            cmd.ram_re = 1'b1;
            state_in   = ST_FORMAT;
         end
         ST_FORMAT: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tcpal_dpath.sv
// Datapath: input capture, colour scaling and packing, palette RAM, result register.
`default_nettype none

module tcpal_dpath #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tcpal_pkg::cfg_type      cfg,
   input  wire tcpal_pkg::req_item_type req_item,
   input  wire tcpal_pkg::cmd_type      cmd,
   output tcpal_pkg::sts_type           sts,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output tcpal_pkg::rsp_item_type      rsp_item
);
   import tcpal_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int RW = 80;   // [47:0] raw request, [79:48] realised colour

   // clamp to 0..1000, then (2*c*gun + 1000) / 16; the /125 follows next cycle
   function automatic logic [14:0] pre_scale(input logic signed [15:0] x,
                                             input logic [7:0] gun);
      logic [9:0]  c;
      logic [17:0] p;
      logic [18:0] n;
      if (x[15]) begin
         c = '0;
      end else if (x > 16'sd1000) begin
         c = 10'(FULL_SCALE);
      end else begin
         c = x[9:0];
      end
      p = 18'(c) * 18'(gun);
      n = {p, 1'b0} + 19'(FULL_SCALE);
      return n[18:4];
   endfunction

   function automatic logic [7:0] div125(input logic [14:0] m);
      logic [30:0] p;
      p = 31'(m) * 31'(RECIP);
      return p[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

   req_item_type item_ff;
   logic         pen_ok_ff;
   logic [14:0]  scale_ff [3];
   logic [7:0]   quot_ff  [3];
   logic [7:0]   gun      [3];
   logic         new_pen_ok;

   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;
   logic         rsp_valid_ff;

   logic [RW-1:0] ram_wdata;
   logic [RW-1:0] ram_rdata;
   logic [31:0]   packed_word;
   logic [15:0]   word16;
   logic [31:0]   stored_word;

   assign new_pen_ok = !req_item.pen[15] && (req_item.pen[14:0] < 15'(PALETTE_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff   <= req_item;
         pen_ok_ff <= new_pen_ok;
      end
   end

   always_comb begin
      if (!cfg.depth_mode) begin
         gun[0] = 8'(GUN32);
         gun[1] = 8'(GUN32);
         gun[2] = 8'(GUN32);
      end else begin
         gun[0] = 8'(GUN16);
         gun[1] = cfg.green_six_bit ? 8'(GUN16X2) : 8'(GUN16);
         gun[2] = 8'(GUN16);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_scale) begin
         scale_ff[0] <= pre_scale(item_ff.red_in,   gun[0]);
         scale_ff[1] <= pre_scale(item_ff.green_in, gun[1]);
         scale_ff[2] <= pre_scale(item_ff.blue_in,  gun[2]);
      end
      if (cmd.load_quot) begin
         quot_ff[0] <= div125(scale_ff[0]);
         quot_ff[1] <= div125(scale_ff[1]);
         quot_ff[2] <= div125(scale_ff[2]);
      end
   end

   // packing of the guns into the realised word
   always_comb begin
      word16 = (16'(quot_ff[0]) << 11) | 16'(quot_ff[2]);
      if (cfg.green_six_bit) begin
         word16 = word16 | (16'(quot_ff[1]) << 5);
      end else begin
         word16 = word16 | (16'(quot_ff[1]) << 6);
      end
      word16 = (word16 | cfg.or_mask) & cfg.and_mask;
      if (!cfg.depth_mode) begin
         packed_word = {8'd0, quot_ff[0], quot_ff[1], quot_ff[2]};
      end else begin
         packed_word = {word16, word16};
      end
   end

   assign ram_wdata = {packed_word, item_ff.blue_in, item_ff.green_in, item_ff.red_in};

   tcpal_ram #(
      .WIDTH (RW),
      .DEPTH (PALETTE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (item_ff.pen[AW-1:0]),
      .wdata (ram_wdata),
      .re    (cmd.ram_re),
      .raddr (item_ff.pen[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign stored_word = ram_rdata[79:48];

   always_comb begin
      rsp_in = '0;
      if (!pen_ok_ff) begin
         rsp_in.pen_echo = -9'sd1;
      end else begin
         rsp_in.pen_echo = {1'b0, item_ff.pen[7:0]};
         if (item_ff.report_realized) begin
            if (!cfg.depth_mode) begin
               rsp_in.red_out   = 16'(BACK8[stored_word[23:16]]);
               rsp_in.green_out = 16'(BACK8[stored_word[15:8]]);
               rsp_in.blue_out  = 16'(BACK8[stored_word[7:0]]);
            end else begin
               rsp_in.red_out = 16'(BACK5[stored_word[15:11]]);
               if (cfg.green_six_bit) begin
                  // lowest green bit is dropped on readback
                  rsp_in.green_out = 16'(BACK6[{stored_word[10:6], 1'b0}]);
               end else begin
                  rsp_in.green_out = 16'(BACK5[stored_word[10:6]]);
               end
               rsp_in.blue_out = 16'(BACK5[stored_word[4:0]]);
            end
         end else begin
            rsp_in.red_out   = ram_rdata[15:0];
            rsp_in.green_out = ram_rdata[31:16];
            rsp_in.blue_out  = ram_rdata[47:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_item      = rsp_ff;
   assign sts.new_query = (req_item.operation == OP_QUERY);
   assign sts.pen_ok    = pen_ok_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

FILE: rtl/truecolor_palette_set_query_unit.sv
// Top level of the truecolour palette set/query unit with its register port.
`default_nettype none

// Palette of PALETTE_ENTRIES pens. A set word keeps the raw red, green and
// blue request (thousandths) and a realised colour: each component clamped to
// 0..1000, scaled to its gun range with round-half-up, packed 8:8:8 or, in
// 16-bit mode, as 5:5/6:5 with the OR and AND masks applied and the 16-bit
// value copied into both halves. A query word returns one result: either the
// stored request or the realised colour scaled back to 0..1000 using the
// packing registers current at query time; an out-of-range or negative pen
// answers pen_echo -1 with zero components, while a bad pen on a set is
// dropped silently. Sets give no result. The unit takes one word at a time; a
// set occupies it from acceptance through the clamp and gun multiply, the
// reciprocal divide by 125 and then the RAM write; a query through the RAM
// read with its registered output and then the back-scaling tables, plus any
// wait of the result register for rsp_tready. A pending result does not
// stop the next word being taken. Querying a pen never set returns undefined
// components. Registers should only be written while the unit is idle.
module truecolor_palette_set_query_unit #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // pen, red_in, green_in, blue_in
   input  wire logic [1:0]  req_tuser,   // operation, report_realized
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // pen_echo, red_out, green_out, blue_out, pad
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tcpal_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         csr_write;
   req_item_type req_item;
   rsp_item_type rsp_item;
   cmd_type      cmd;
   sts_type      sts;

   // --- register port: writes land on the access phase, reads are plain muxing
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_DEPTH_MODE: cfg_in.depth_mode    = csr_pwdata[0];
            REG_GREEN_SIX:  cfg_in.green_six_bit = csr_pwdata[0];
            REG_OR_MASK:    cfg_in.or_mask       = csr_pwdata[15:0];
            REG_AND_MASK:   cfg_in.and_mask      = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode    <= 1'b0;
         cfg_ff.green_six_bit <= 1'b0;
         cfg_ff.or_mask       <= 16'h0000;
         cfg_ff.and_mask      <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_DEPTH_MODE: csr_prdata = {31'd0, cfg_ff.depth_mode};
         REG_GREEN_SIX:  csr_prdata = {31'd0, cfg_ff.green_six_bit};
         REG_OR_MASK:    csr_prdata = {16'd0, cfg_ff.or_mask};
         REG_AND_MASK:   csr_prdata = {16'd0, cfg_ff.and_mask};
         default:        csr_prdata = '0;
      endcase
   end

   // --- stream field unpacking / packing
   assign req_item.operation       = req_tuser[0];
   assign req_item.report_realized = req_tuser[1];
   assign req_item.pen             = req_tdata[15:0];
   assign req_item.red_in          = req_tdata[31:16];
   assign req_item.green_in        = req_tdata[47:32];
   assign req_item.blue_in         = req_tdata[63:48];

   assign rsp_tdata = {7'd0, rsp_item.blue_out, rsp_item.green_out,
                       rsp_item.red_out, rsp_item.pen_echo};

   tcpal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcpal_dpath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // --- checks
   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while pending");

   // while taking a word the sequencer is not touching the RAM or the result
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(cmd.ram_we || cmd.ram_re || cmd.load_rsp))
      else $error("datapath command issued while accepting");

   // a result only appears after a query was formatted
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_rsp))
      else $error("result appeared without a load");

   // RAM never read and written in the same cycle
   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ram_we && cmd.ram_re))
      else $error("RAM read and write together");

endmodule

`default_nettype wire

FILE: tb/tcpal_palette_checker.sv
// Channel monitor for the palette unit: predicts query answers and compares them.
module tcpal_palette_checker #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatch_count,
   output int               answers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import tcpal_pkg::*;

   // shadow of the palette contents
   logic [15:0] asked_red   [PALETTE_ENTRIES];
   logic [15:0] asked_green [PALETTE_ENTRIES];
   logic [15:0] asked_blue  [PALETTE_ENTRIES];
   logic [31:0] realised    [PALETTE_ENTRIES];

   // shadow of the packing registers
   logic        cfg_deep;
   logic        cfg_green6;
   logic [15:0] cfg_or;
   logic [15:0] cfg_and;

   rsp_item_type due_answers[$];
   int fault_total = 0;

   assign mismatch_count = fault_total;

   task automatic flag_mismatch(string what, longint got, longint want);
      fault_total++;
      $display("%0t palette mismatch: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // round(a*b/c), halves up
   function automatic int unsigned round_ratio(int unsigned a, int unsigned b,
                                                int unsigned c);
      return (2 * a * b + c) / (2 * c);
   endfunction

   function automatic int unsigned clamp_thou(logic signed [15:0] v);
      if (v < 0) return 0;
      if (v > 1000) return FULL_SCALE;
      return int'(v);
   endfunction

   function automatic logic pen_ok(logic signed [15:0] pen);
      return !pen[15] && (pen < PALETTE_ENTRIES);
   endfunction

   function automatic logic [31:0] realise(logic signed [15:0] r, logic signed [15:0] g,
                                           logic signed [15:0] b);
      int unsigned rc;
      int unsigned gc;
      int unsigned bc;
      logic [15:0] w;
      rc = clamp_thou(r);
      gc = clamp_thou(g);
      bc = clamp_thou(b);
      if (!cfg_deep) begin
         return {8'h00, 8'(round_ratio(rc, GUN32, FULL_SCALE)),
                 8'(round_ratio(gc, GUN32, FULL_SCALE)),
                 8'(round_ratio(bc, GUN32, FULL_SCALE))};
      end
      w = 16'(round_ratio(rc, GUN16, FULL_SCALE) << 11);
      if (cfg_green6) w = w | 16'(round_ratio(gc, GUN16X2, FULL_SCALE) << 5);
      else            w = w | 16'(round_ratio(gc, GUN16, FULL_SCALE) << 6);
      w = w | 16'(round_ratio(bc, GUN16, FULL_SCALE));
      w = (w | cfg_or) & cfg_and;
      return {w, w};
   endfunction

   // answer to a query, read with the packing registers as they are now
   function automatic rsp_item_type answer_query(logic signed [15:0] pen, logic want_real);
      rsp_item_type a;
      logic [31:0] w;
      int idx;
      a = '0;
      if (!pen_ok(pen)) begin
         a.pen_echo = -9'sd1;
         return a;
      end
      idx = int'(pen);
      a.pen_echo = pen[8:0];
      if (!want_real) begin
         a.red_out   = asked_red[idx];
         a.green_out = asked_green[idx];
         a.blue_out  = asked_blue[idx];
         return a;
      end
      w = realised[idx];
      if (!cfg_deep) begin
         a.red_out   = 16'(round_ratio(w[23:16], FULL_SCALE, GUN32));
         a.green_out = 16'(round_ratio(w[15:8], FULL_SCALE, GUN32));
         a.blue_out  = 16'(round_ratio(w[7:0], FULL_SCALE, GUN32));
      end else begin
         a.red_out = 16'(round_ratio(w[15:11], FULL_SCALE, GUN16));
         // six-bit green drops its lowest bit on the way back
         if (cfg_green6) a.green_out = 16'(round_ratio({w[10:6], 1'b0}, FULL_SCALE, GUN16X2));
         else            a.green_out = 16'(round_ratio(w[10:6], FULL_SCALE, GUN16));
         a.blue_out = 16'(round_ratio(w[4:0], FULL_SCALE, GUN16));
      end
      return a;
   endfunction

   always @(posedge clock) begin : watch
      logic signed [15:0] pen;
      int idx;
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         cfg_deep   = 1'b0;
         cfg_green6 = 1'b0;
         cfg_or     = 16'h0000;
         cfg_and    = 16'hFFFF;
         due_answers.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_DEPTH_MODE: cfg_deep   = csr_pwdata[0];
               REG_GREEN_SIX:  cfg_green6 = csr_pwdata[0];
               REG_OR_MASK:    cfg_or     = csr_pwdata[15:0];
               REG_AND_MASK:   cfg_and    = csr_pwdata[15:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            pen = req_tdata[15:0];
            if (req_tuser[0] == OP_SET) begin
               if (pen_ok(pen)) begin
                  idx = int'(pen);
                  asked_red[idx]   = req_tdata[31:16];
                  asked_green[idx] = req_tdata[47:32];
                  asked_blue[idx]  = req_tdata[63:48];
                  realised[idx]    = realise(req_tdata[31:16], req_tdata[47:32],
                                             req_tdata[63:48]);
               end
            end else begin
               due_answers.push_back(answer_query(pen, req_tuser[1]));
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            seen.pen_echo  = rsp_tdata[8:0];
            seen.red_out   = rsp_tdata[24:9];
            seen.green_out = rsp_tdata[40:25];
            seen.blue_out  = rsp_tdata[56:41];
            if (due_answers.size() == 0) begin
               flag_mismatch("answer with none due, pen_echo", seen.pen_echo, 0);
            end else begin
               want = due_answers.pop_front();
               if (seen.pen_echo != want.pen_echo)
                  flag_mismatch("pen_echo", seen.pen_echo, want.pen_echo);
               if (seen.red_out != want.red_out)
                  flag_mismatch("red_out", seen.red_out, want.red_out);
               if (seen.green_out != want.green_out)
                  flag_mismatch("green_out", seen.green_out, want.green_out);
               if (seen.blue_out != want.blue_out)
                  flag_mismatch("blue_out", seen.blue_out, want.blue_out);
               if (rsp_tdata[63:57] != 7'd0)
                  flag_mismatch("pad bits", rsp_tdata[63:57], 0);
            end
         end
      end
      answers_pending <= due_answers.size();
   end

endmodule

FILE: tb/tb_truecolor_palette_set_query_unit.sv
// Stimulus and verdict for the truecolour palette set/query unit.
module tb_truecolor_palette_set_query_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpal_pkg::*;

   localparam int PENS = 256;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // pen, red_in, green_in, blue_in
   logic [1:0]  req_tuser;   // operation, report_realized
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // pen_echo, red_out, green_out, blue_out, pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int answers_pending;

   // idling odds in percent, and the receiver's long hold-off in cycles
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_left = 0;

   // pens that a set has written; queries of valid pens stay within these
   bit                 pen_written [PENS];
   logic signed [15:0] written_pens[$];

   truecolor_palette_set_query_unit #(
      .PALETTE_ENTRIES(PENS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tcpal_palette_checker #(
      .PALETTE_ENTRIES(PENS)
   ) palette_watch (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   always #5 clock = ~clock;

   // Result side. Random back-pressure at rx_idle_pct, unless a long hold-off
   // has been asked for, in which case tready stays low until rx_hold_left runs out
   // while the sender keeps going and the unit backs up onto its input.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rx_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Hard stop in case the unit hangs
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic valid_pen(logic signed [15:0] pen);
      return !pen[15] && (pen < PENS);
   endfunction

   // Out-of-range pen: either a large positive index or a negative one
   function automatic logic signed [15:0] stray_pen();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(PENS, 32767));
      return {1'b1, 15'($urandom)};
   endfunction

   // Component in thousandths: mostly in range, some on the clamp edges,
   // the rest anywhere in the 16-bit field
   function automatic logic signed [15:0] pick_thou();
      logic signed [15:0] edges [8];
      edges = '{-16'sd1, 16'sd0, 16'sd1, 16'sd999, 16'sd1000, 16'sd1001,
                -16'sd32768, 16'sd32767};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 16'($urandom_range(0, 1000));
         5:             return edges[$urandom_range(0, 7)];
         default:       return 16'($urandom);
      endcase
   endfunction

   // One request word. Entered and left on a rising edge; on return the word
   // has just been taken and tvalid is still high, so the next call may keep it up.
   task automatic send_word(logic [0:0] op, logic signed [15:0] pen, logic signed [15:0] r,
                            logic signed [15:0] g, logic signed [15:0] b, logic want_real);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r, pen};
      req_tuser  <= {want_real, op};
      do @(posedge clock); while (!req_tready);
      if (op == OP_SET && valid_pen(pen) && !pen_written[pen]) begin
         pen_written[pen] = 1'b1;
         written_pens.push_back(pen);
      end
   endtask

   // Drop tvalid and wait until every query has been answered, then give a
   // set still in flight time to reach the RAM.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup cycle, then access cycle, then an idle spell with psel low so back-to-back
   // writes never drive psel twice in the same step
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_packing(logic deep, logic green6, logic [15:0] orm, logic [15:0] andm);
      write_reg(REG_DEPTH_MODE, {31'd0, deep});
      write_reg(REG_GREEN_SIX, {31'd0, green6});
      write_reg(REG_OR_MASK, {16'd0, orm});
      write_reg(REG_AND_MASK, {16'd0, andm});
   endtask

   // A stretch of random words under one packing setting. Sets to a stray pen
   // are dropped by the unit and are not counted. At word hold_at the receiver
   // holds off for a long while; at word pause_at the sender waits for every
   // answer to come back.
   task automatic run_segment(int tx_pct, int rx_pct, logic deep, logic green6,
                              logic [15:0] orm, logic [15:0] andm, int words,
                              int hold_at, int pause_at);
      int done;
      logic [0:0] op;
      logic signed [15:0] pen;
      settle();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      set_packing(deep, green6, orm, andm);
      done = 0;
      while (done < words) begin
         if (done == hold_at) rx_hold_left = 150;
         if (done == pause_at) settle();
         op = ($urandom_range(0, 1) == 0) ? OP_SET : OP_QUERY;
         if ($urandom_range(0, 3) == 0) begin
            pen = stray_pen();
         end else if (op == OP_SET) begin
            pen = 16'($urandom_range(0, PENS - 1));
         end else if ($urandom_range(0, 2) == 0) begin
            // read back the pen most recently written for the first time
            pen = written_pens[written_pens.size() - 1];
         end else begin
            pen = written_pens[$urandom_range(0, written_pens.size() - 1)];
         end
         send_word(op, pen, pick_thou(), pick_thou(), pick_thou(), 1'($urandom));
         if (!(op == OP_SET && !valid_pen(pen))) done++;
      end
   endtask

   initial begin : stimulus
      int waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: 32-bit packing ---
      set_packing(1'b0, 1'b0, 16'h0000, 16'hFFFF);
      // both clamps at once, then full scale with a half that rounds up
      send_word(OP_SET, 16'sd0, -16'sd32768, 16'sd32767, 16'sd1000, 1'b0);
      send_word(OP_SET, 16'sd255, 16'sd1000, 16'sd0, 16'sd100, 1'b1);
      send_word(OP_SET, 16'sd1, 16'sd2, 16'sd999, 16'sd1, 1'b0);
      send_word(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_word(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, 16'sd255, -16'sd1, -16'sd1, -16'sd1, 1'b1);
      send_word(OP_QUERY, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      // sets to bad pens vanish; queries of bad pens answer -1
      send_word(OP_SET, 16'sd256, 16'sd500, 16'sd500, 16'sd500, 1'b0);
      send_word(OP_SET, -16'sd1, 16'sd500, 16'sd500, 16'sd500, 1'b0);
      send_word(OP_QUERY, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_word(OP_QUERY, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, 16'sd32767, -16'sd1, -16'sd1, -16'sd1, 1'b0);

      // --- directed: 16-bit, five-bit green ---
      settle();
      set_packing(1'b1, 1'b0, 16'h0000, 16'hFFFF);
      // pen 255 was packed 8:8:8 and is now read as 16-bit
      send_word(OP_QUERY, 16'sd255, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_SET, 16'sd2, 16'sd1000, 16'sd1000, 16'sd1000, 1'b0);
      send_word(OP_SET, 16'sd3, 16'sd500, 16'sd17, 16'sd984, 1'b0);
      send_word(OP_QUERY, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 1'b1);

      // --- directed: 16-bit, six-bit green, masks in play ---
      settle();
      set_packing(1'b1, 1'b1, 16'h0021, 16'hFFDF);
      send_word(OP_SET, 16'sd4, 16'sd0, 16'sd1000, 16'sd0, 1'b0);
      send_word(OP_QUERY, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_word(OP_QUERY, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 1'b0);

      // --- random: sender light/receiver heavy, swapped, then no idling ---
      run_segment(22, 58, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 130, 40, -1);
      run_segment(22, 58, 1'b1, 1'b0, 16'($urandom), 16'($urandom), 130, -1, 60);
      run_segment(58, 22, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 130, -1, -1);
      run_segment(58, 22, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 130, 50, -1);
      run_segment(0, 0, 1'b0, 1'b1, 16'($urandom), 16'($urandom), 130, -1, -1);
      run_segment(0, 0, 1'b1, 1'b0, 16'($urandom), 16'($urandom), 130, 20, 70);

      // --- wind down: wait for the last answers, bounded ---
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (answers_pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (answers_pending != 0) $display("%0d answers never returned", answers_pending);

      if (mismatch_count == 0 && answers_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: truecolor_palette_set_query_unit.f
rtl/tcpal_pkg.sv
rtl/tcpal_ram.sv
rtl/tcpal_ctrl.sv
rtl/tcpal_dpath.sv
rtl/truecolor_palette_set_query_unit.sv
tb/tcpal_palette_checker.sv
tb/tb_truecolor_palette_set_query_unit.sv
